FILE: rtl/core/lsjt_pkg.sv
`default_nettype none
package lsjt_pkg;

	// item kinds
	typedef enum logic [1:0] {
		KIND_SAMPLE   = 2'd0,
		KIND_CLR_TURN = 2'd1,
		KIND_CLR_PAT  = 2'd2,
		KIND_CLR_NODE = 2'd3
	} kind_t;

	// configuration register indexes
	localparam logic [1:0] CFG_REPEAT_LIMIT     = 2'd0;
	localparam logic [1:0] CFG_WHITE_LIMIT      = 2'd1;
	localparam logic [1:0] CFG_BLACK_STOP_LIMIT = 2'd2;

	// configuration reset values
	localparam logic [7:0] RST_REPEAT_LIMIT     = 8'd3;
	localparam logic [7:0] RST_WHITE_LIMIT      = 8'd10;
	localparam logic [7:0] RST_BLACK_STOP_LIMIT = 8'd30;

	// sensor patterns of interest
	localparam logic [4:0] PAT_WHITE   = 5'b00000;
	localparam logic [4:0] PAT_BLACK   = 5'b11111;
	localparam logic [4:0] PAT_LEFT_A  = 5'b11100;
	localparam logic [4:0] PAT_LEFT_B  = 5'b11110;
	localparam logic [4:0] PAT_RIGHT_A = 5'b00111;
	localparam logic [4:0] PAT_RIGHT_B = 5'b01111;
	localparam logic [4:0] MASK_MID    = 5'b01110;
	localparam logic [4:0] MASK_OUTER  = 5'b10001;

	localparam logic [7:0] COUNT_MAX = 8'hff;

	typedef struct packed {
		kind_t      kind;
		logic [4:0] pattern;
		logic       judge_enable;
	} sample_t;

	typedef struct packed {
		logic signed [3:0] steer_error;
		logic              node_detect;
		logic              stop;
		logic              turn_left;
		logic              turn_right;
		logic              both_sides;
		logic              straight_ahead;
		logic              pending;
	} result_t;

	typedef struct packed {
		logic [7:0] repeat_limit;
		logic [7:0] white_limit;
		logic [7:0] black_stop_limit;
	} limits_t;

	typedef struct packed {
		logic straight;
		logic both;
		logic right;
		logic left;
	} turn_t;

	typedef struct packed {
		logic              hit;
		logic signed [3:0] err;
	} line_err_t;

	// saturating counter step
	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == COUNT_MAX) ? v : v + 8'd1;
	endfunction

	// single-line shapes to steering error
	function automatic line_err_t line_error(input logic [4:0] p);
		line_err_t r;
		r.hit = 1'b1;
		case (p)
			5'b00001: r.err = -4'sd6;
			5'b00011: r.err = -4'sd4;
			5'b00010: r.err = -4'sd3;
			5'b00110: r.err = -4'sd2;
			5'b00100: r.err = 4'sd0;
			5'b01110: r.err = 4'sd0;
			5'b01100: r.err = 4'sd2;
			5'b01000: r.err = 4'sd3;
			5'b11000: r.err = 4'sd4;
			5'b10000: r.err = 4'sd6;
			default: begin
				r.hit = 1'b0;
				r.err = 4'sd0;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lsjt_core.sv
`default_nettype none
module lsjt_core import lsjt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire sample_t item,
	input  wire limits_t lim,
	output result_t      res
);

	logic [4:0]        prev_q, prev_n;
	logic [7:0]        white_q, white_n;
	logic [7:0]        black_q, black_n;
	logic [7:0]        left_q, left_n;
	logic [7:0]        right_q, right_n;
	logic signed [3:0] err_q, err_n;
	logic              node_q, node_n;
	logic              stop_q, stop_n;
	turn_t             turn_q, turn_n;
	logic              pend_q, pend_n;
	logic              same;
	line_err_t         lerr;

	assign same = item.judge_enable && (prev_q == item.pattern);
	assign lerr = line_error(item.pattern);

	// next tracker state for the item in hand
	always_comb begin
		prev_n  = prev_q;
		white_n = white_q;
		black_n = black_q;
		left_n  = left_q;
		right_n = right_q;
		err_n   = err_q;
		node_n  = node_q;
		stop_n  = stop_q;
		turn_n  = turn_q;
		pend_n  = pend_q;
		case (item.kind)
			KIND_SAMPLE: begin
				if (lerr.hit) begin
					err_n = lerr.err;
				end else if (item.pattern == PAT_WHITE) begin
					if (same) begin
						black_n = '0;
						white_n = sat_inc(white_q);
						if (white_n > lim.white_limit) begin
							node_n = 1'b1;
							pend_n = 1'b0;
						end
					end else begin
						white_n = '0;
					end
				end else if (item.pattern == PAT_BLACK) begin
					if (same) begin
						white_n = '0;
						black_n = sat_inc(black_q);
						if (black_n > lim.black_stop_limit) begin
							err_n       = '0;
							stop_n      = 1'b1;
							node_n      = 1'b1;
							turn_n.both = 1'b0;
							pend_n      = 1'b0;
						end else if (black_n >= lim.repeat_limit) begin
							pend_n      = 1'b1;
							turn_n.both = 1'b1;
						end
					end else begin
						black_n = '0;
					end
				end else if (item.pattern == PAT_LEFT_A || item.pattern == PAT_LEFT_B) begin
					if (same) begin
						white_n = '0;
						black_n = '0;
						left_n  = sat_inc(left_q);
						if (left_n >= lim.repeat_limit) begin
							pend_n      = 1'b1;
							turn_n.left = 1'b1;
						end
					end else begin
						left_n = '0;
					end
				end else if (item.pattern == PAT_RIGHT_A || item.pattern == PAT_RIGHT_B) begin
					if (same) begin
						white_n = '0;
						black_n = '0;
						right_n = sat_inc(right_q);
						if (right_n >= lim.repeat_limit) begin
							pend_n       = 1'b1;
							turn_n.right = 1'b1;
						end
					end else begin
						right_n = '0;
					end
				end else begin
					err_n = '0;
				end
				// a changed judged pattern that is white or lights only the middle sensors resolves a pending junction
				if (item.judge_enable && pend_n && (prev_q != item.pattern)) begin
					if (item.pattern == PAT_WHITE) begin
						node_n = 1'b1;
						pend_n = 1'b0;
					end else if ((item.pattern & MASK_MID) != '0 &&
						(item.pattern & MASK_OUTER) == '0) begin
						node_n          = 1'b1;
						turn_n.straight = 1'b1;
						pend_n          = 1'b0;
					end
				end
				prev_n = item.pattern;
			end
			KIND_CLR_TURN: begin
				turn_n  = '0;
				white_n = '0;
				black_n = '0;
				left_n  = '0;
				right_n = '0;
			end
			KIND_CLR_PAT: begin
				prev_n = '0;
			end
			KIND_CLR_NODE: begin
				node_n = 1'b0;
				stop_n = 1'b0;
			end
			default: begin
				prev_n = prev_q;
			end
		endcase
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			white_q <= '0;
			black_q <= '0;
			left_q  <= '0;
			right_q <= '0;
			err_q   <= '0;
			node_q  <= 1'b0;
			stop_q  <= 1'b0;
			turn_q  <= '0;
			pend_q  <= 1'b0;
		end else if (step) begin
			prev_q  <= prev_n;
			white_q <= white_n;
			black_q <= black_n;
			left_q  <= left_n;
			right_q <= right_n;
			err_q   <= err_n;
			node_q  <= node_n;
			stop_q  <= stop_n;
			turn_q  <= turn_n;
			pend_q  <= pend_n;
		end
	end

	// result shows the state after the item
	always_comb begin
		res.steer_error    = err_n;
		res.node_detect    = node_n;
		res.stop           = stop_n;
		res.turn_left      = turn_n.left;
		res.turn_right     = turn_n.right;
		res.both_sides     = turn_n.both;
		res.straight_ahead = turn_n.straight;
		res.pending        = pend_n;
	end

	// stop is only ever raised together with node and cleared with it
	assert property (@(posedge clk) disable iff (!arst_n) stop_q |-> node_q)
		else $error("stop flag without node flag");

	// held error stays within the table range
	assert property (@(posedge clk) disable iff (!arst_n)
		(err_q >= -4'sd6) && (err_q <= 4'sd6))
		else $error("held error out of range");

	// a clear-turn item leaves no turn flag and no counter
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.kind == KIND_CLR_TURN) |=>
		(turn_q == '0) && (left_q == '0) && (right_q == '0) &&
		(white_q == '0) && (black_q == '0))
		else $error("clear turn left state behind");

endmodule
`default_nettype wire

FILE: rtl/core/line_sensor_junction_tracker.sv
`default_nettype none
// channel  | signals                               | direction
// ---------+---------------------------------------+----------
// sample   | sample_valid, sample_stall, sample    | in
// result   | result_valid, result_stall, result    | out
// cfg      | cfg_valid, cfg_ready, cfg_index/data  | in
//
// One sample per cycle while sample_stall is low; each result passes the input
// register, then the result register, before its transfer.
// arst_n clears state and loads the limit registers with their defaults.
// A stalled result holds the result register; the input register still
// takes one more item, then sample_stall rises until the result moves.
// cfg_ready is always high.
module line_sensor_junction_tracker import lsjt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       sample_valid,
	output logic            sample_stall,
	input  wire sample_t    sample,
	output logic            result_valid,
	input  wire logic       result_stall,
	output result_t         result,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic    in_valid_s1;
	sample_t in_item_s1;
	logic    out_valid_s2;
	result_t out_item_s2;
	limits_t lim_q;
	logic    advance;
	logic    load_s1;
	result_t res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.repeat_limit     <= RST_REPEAT_LIMIT;
			lim_q.white_limit      <= RST_WHITE_LIMIT;
			lim_q.black_stop_limit <= RST_BLACK_STOP_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REPEAT_LIMIT:     lim_q.repeat_limit     <= cfg_data;
				CFG_WHITE_LIMIT:      lim_q.white_limit      <= cfg_data;
				CFG_BLACK_STOP_LIMIT: lim_q.black_stop_limit <= cfg_data;
				default:              lim_q                  <= lim_q;
			endcase
		end
	end

	// handshake control
	assign advance      = in_valid_s1 && !(out_valid_s2 && result_stall);
	assign sample_stall = in_valid_s1 && out_valid_s2 && result_stall;
	assign load_s1      = sample_valid && !sample_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (load_s1 || advance) begin
			in_valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			in_item_s1 <= sample;
		end
	end

	lsjt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (in_item_s1),
		.lim    (lim_q),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_s2 <= res;
		end
	end

	assign result_valid = out_valid_s2;
	assign result       = out_item_s2;

	// back-pressure only when both stages are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (in_valid_s1 && out_valid_s2))
		else $error("stall without full pipeline");

	// an item that moves on always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_s2)
		else $error("advanced item lost");

	// a held result is not dropped while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && result_stall && !advance) |=>
		(out_valid_s2 && $stable(out_item_s2)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import lsjt_pkg::*;

	localparam int         CYCLE_LIMIT = 200000;
	localparam logic [1:0] CFG_UNUSED  = 2'd3;

	// junction tracking predictor and the queue of results still owed by the block
	class junction_scoreboard;
		limits_t           lim;
		logic [4:0]        prev_pat;
		logic [7:0]        white_run, black_run, left_run, right_run;
		logic signed [3:0] err_hold;
		logic              node_q, stop_q, pend;
		turn_t             turns;
		result_t           expected_results[$];
		int                fails;
		int                checked;
		int                stops_seen;

		function new();
			lim.repeat_limit = RST_REPEAT_LIMIT;
			lim.white_limit = RST_WHITE_LIMIT;
			lim.black_stop_limit = RST_BLACK_STOP_LIMIT;
			prev_pat = '0;
			white_run = '0;
			black_run = '0;
			left_run = '0;
			right_run = '0;
			err_hold = '0;
			node_q = 1'b0;
			stop_q = 1'b0;
			pend = 1'b0;
			turns = '0;
			fails = 0;
			checked = 0;
			stops_seen = 0;
		endfunction

		function void set_limit(logic [1:0] idx, logic [7:0] d);
			case (idx)
				CFG_REPEAT_LIMIT: lim.repeat_limit = d;
				CFG_WHITE_LIMIT: lim.white_limit = d;
				CFG_BLACK_STOP_LIMIT: lim.black_stop_limit = d;
				default: ;
			endcase
		endfunction

		// counters stick at all ones
		function logic [7:0] bump(logic [7:0] v);
			return (v == 8'hff) ? v : v + 8'd1;
		endfunction

		// single-line shapes and their lateral offset
		function bit steer_of(input logic [4:0] p, output logic signed [3:0] e);
			e = '0;
			case (p)
				5'b00001: e = -4'sd6;
				5'b00011: e = -4'sd4;
				5'b00010: e = -4'sd3;
				5'b00110: e = -4'sd2;
				5'b00100: e = 4'sd0;
				5'b01110: e = 4'sd0;
				5'b01100: e = 4'sd2;
				5'b01000: e = 4'sd3;
				5'b11000: e = 4'sd4;
				5'b10000: e = 4'sd6;
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		function void judge_sample(logic [4:0] p, logic judge);
			logic signed [3:0] e;
			bit                same;
			same = judge && (prev_pat == p);
			if (steer_of(p, e)) begin
				err_hold = e;
			end else if (p == PAT_WHITE) begin
				if (same) begin
					black_run = '0;
					white_run = bump(white_run);
					if (white_run > lim.white_limit) begin
						node_q = 1'b1;
						pend = 1'b0;
					end
				end else begin
					white_run = '0;
				end
			end else if (p == PAT_BLACK) begin
				if (same) begin
					white_run = '0;
					black_run = bump(black_run);
					if (black_run > lim.black_stop_limit) begin
						err_hold = '0;
						stop_q = 1'b1;
						node_q = 1'b1;
						turns.both = 1'b0;
						pend = 1'b0;
					end else if (black_run >= lim.repeat_limit) begin
						pend = 1'b1;
						turns.both = 1'b1;
					end
				end else begin
					black_run = '0;
				end
			end else if (p == PAT_LEFT_A || p == PAT_LEFT_B) begin
				if (same) begin
					white_run = '0;
					black_run = '0;
					left_run = bump(left_run);
					if (left_run >= lim.repeat_limit) begin
						pend = 1'b1;
						turns.left = 1'b1;
					end
				end else begin
					left_run = '0;
				end
			end else if (p == PAT_RIGHT_A || p == PAT_RIGHT_B) begin
				if (same) begin
					white_run = '0;
					black_run = '0;
					right_run = bump(right_run);
					if (right_run >= lim.repeat_limit) begin
						pend = 1'b1;
						turns.right = 1'b1;
					end
				end else begin
					right_run = '0;
				end
			end else begin
				err_hold = '0;
			end
			// a pattern change after a junction settles it
			if (judge && pend && prev_pat != p) begin
				if (p == PAT_WHITE) begin
					node_q = 1'b1;
					pend = 1'b0;
				end else if ((p & MASK_MID) != '0 && (p & MASK_OUTER) == '0) begin
					node_q = 1'b1;
					turns.straight = 1'b1;
					pend = 1'b0;
				end
			end
			prev_pat = p;
		endfunction

		function void predict_item(sample_t s);
			result_t r;
			case (s.kind)
				KIND_SAMPLE: judge_sample(s.pattern, s.judge_enable);
				KIND_CLR_TURN: begin
					turns = '0;
					white_run = '0;
					black_run = '0;
					left_run = '0;
					right_run = '0;
				end
				KIND_CLR_PAT: prev_pat = '0;
				default: begin
					node_q = 1'b0;
					stop_q = 1'b0;
				end
			endcase
			r.steer_error = err_hold;
			r.node_detect = node_q;
			r.stop = stop_q;
			r.turn_left = turns.left;
			r.turn_right = turns.right;
			r.both_sides = turns.both;
			r.straight_ahead = turns.straight;
			r.pending = pend;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s expected %0d actual %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(result_t r);
			result_t w;
			if (expected_results.size() == 0) begin
				$error("result transfer with no expected result waiting");
				fails++;
				return;
			end
			w = expected_results.pop_front();
			checked++;
			if (r.stop)
				stops_seen++;
			compare_field("steer_error", int'(w.steer_error), int'(r.steer_error));
			compare_field("node_detect", w.node_detect, r.node_detect);
			compare_field("stop", w.stop, r.stop);
			compare_field("turn_left", w.turn_left, r.turn_left);
			compare_field("turn_right", w.turn_right, r.turn_right);
			compare_field("both_sides", w.both_sides, r.both_sides);
			compare_field("straight_ahead", w.straight_ahead, r.straight_ahead);
			compare_field("pending", w.pending, r.pending);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       sample_valid;
	logic       sample_stall;
	sample_t    sample;
	logic       result_valid;
	logic       result_stall;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	junction_scoreboard sb = new();

	logic [4:0] junction_pats [6] = '{PAT_WHITE, PAT_BLACK, PAT_LEFT_A, PAT_LEFT_B,
		PAT_RIGHT_A, PAT_RIGHT_B};
	logic [4:0] line_pats [10] = '{5'b00001, 5'b00011, 5'b00010, 5'b00110, 5'b00100,
		5'b01110, 5'b01100, 5'b01000, 5'b11000, 5'b10000};

	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold;
	int cycle_count;
	int samples_sent;
	int commands_sent;
	int settings_used;

	line_sensor_junction_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result transfers go to the scoreboard
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// receiver: long hold-offs on request, otherwise random stall bursts
	always begin
		@(negedge clk);
		if (rx_hold > 0) begin
			result_stall <= 1'b1;
			repeat (rx_hold) @(negedge clk);
			rx_hold = 0;
			result_stall <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			repeat ($urandom_range(1, 17)) @(negedge clk);
			result_stall <= 1'b0;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic sample_t mk(kind_t k, logic [4:0] p, logic j);
		sample_t s;
		s.kind = k;
		s.pattern = p;
		s.judge_enable = j;
		return s;
	endfunction

	// one input transfer; entered and left at a falling edge, valid stays up
	task automatic push_item(sample_t s);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		sb.predict_item(s);
		if (s.kind == KIND_SAMPLE)
			samples_sent++;
		else
			commands_sent++;
		@(negedge clk);
	endtask

	// hold the input side until every expected result is back
	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_results.size() != 0);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	// write all limit registers plus the unused index while idle
	task automatic apply_limits(logic [7:0] rep, logic [7:0] wht, logic [7:0] blk);
		logic [1:0] idx [4];
		logic [7:0] val [4];
		idx = '{CFG_REPEAT_LIMIT, CFG_WHITE_LIMIT, CFG_BLACK_STOP_LIMIT, CFG_UNUSED};
		val = '{rep, wht, blk, 8'($urandom_range(0, 255))};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_limit(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// a junction run with random content, a lone pattern, a command or a line run
	task automatic junction_burst();
		logic [4:0] p;
		int         n;
		bit         steady;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				p = junction_pats[$urandom_range(0, 5)];
				n = $urandom_range(1, 40);
				steady = ($urandom_range(0, 4) != 0);
				repeat (n) push_item(mk(KIND_SAMPLE, p,
					steady ? 1'b1 : 1'($urandom_range(0, 1))));
				push_item(mk(KIND_SAMPLE, 5'($urandom_range(0, 31)), 1'b1));
			end
			6, 7: push_item(mk(KIND_SAMPLE, 5'($urandom_range(0, 31)),
				1'($urandom_range(0, 1))));
			8: push_item(mk(kind_t'($urandom_range(1, 3)), 5'($urandom_range(0, 31)),
				1'($urandom_range(0, 1))));
			default: begin
				p = line_pats[$urandom_range(0, 9)];
				repeat ($urandom_range(1, 4)) push_item(mk(KIND_SAMPLE, p,
					1'($urandom_range(0, 1))));
			end
		endcase
	endtask

	task automatic random_phase(int count);
		int stop_at;
		stop_at = samples_sent + commands_sent + count;
		while (samples_sent + commands_sent < stop_at)
			junction_burst();
	endtask

	initial begin
		limits_t setups [5];
		setups = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd1, 8'd2, 8'd5},
			'{8'd2, 8'd255, 8'd0}, '{RST_REPEAT_LIMIT, RST_WHITE_LIMIT, RST_BLACK_STOP_LIMIT}};
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items at reset limits
		push_item(mk(KIND_SAMPLE, 5'b00001, 1'b1));
		push_item(mk(KIND_SAMPLE, 5'b10000, 1'b0));
		push_item(mk(KIND_SAMPLE, 5'b01110, 1'b1));
		push_item(mk(KIND_SAMPLE, 5'b10101, 1'b1));
		push_item(mk(KIND_SAMPLE, 5'b00011, 1'b1));
		repeat (3) push_item(mk(KIND_SAMPLE, PAT_WHITE, 1'b1));
		repeat (4) push_item(mk(KIND_SAMPLE, PAT_BLACK, 1'b1));
		push_item(mk(KIND_SAMPLE, 5'b00100, 1'b1));
		push_item(mk(KIND_CLR_NODE, 5'b00000, 1'b0));
		repeat (4) push_item(mk(KIND_SAMPLE, PAT_LEFT_A, 1'b1));
		push_item(mk(KIND_SAMPLE, PAT_WHITE, 1'b1));
		push_item(mk(KIND_CLR_TURN, 5'b11111, 1'b1));
		push_item(mk(KIND_CLR_PAT, 5'b11111, 1'b1));
		repeat (4) push_item(mk(KIND_SAMPLE, PAT_RIGHT_B, 1'b1));

		// random at reset limits, with a long receiver hold-off to back up the input
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		random_phase(40);
		rx_hold = 300;
		random_phase(60);

		// sweep limit settings, each written while the block is idle
		for (int k = 0; k < 5; k++) begin
			drain();
			apply_limits(setups[k].repeat_limit, setups[k].white_limit,
				setups[k].black_stop_limit);
			tx_idle_on = $urandom_range(0, 1);
			rx_idle_on = $urandom_range(0, 1);
			// counters run into saturation with the largest limits
			if (k == 1) begin
				repeat (270) push_item(mk(KIND_SAMPLE, PAT_BLACK, 1'b1));
				repeat (260) push_item(mk(KIND_SAMPLE, PAT_WHITE, 1'b1));
			end
			random_phase(45);
		end

		// random limits, and a closing stretch with no idling
		drain();
		apply_limits(8'($urandom_range(1, 8)), 8'($urandom_range(0, 40)),
			8'($urandom_range(0, 40)));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		random_phase(90);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		random_phase(90);

		drain();
		if (sb.expected_results.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_results.size());
			sb.fails++;
		end
		$display("run covered %0d samples and %0d commands over %0d limit settings",
			samples_sent, commands_sent, settings_used);
		$display("%0d results checked, %0d with stop raised", sb.checked, sb.stops_seen);
		if (sb.fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/lsjt_pkg.sv
rtl/core/lsjt_core.sv
rtl/core/line_sensor_junction_tracker.sv
tb/tb.sv
